FILE: hdl/tws_pkg.sv
package tws_pkg;

	// Event codes on the operation field.
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_PACKET = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_READY  = 2'd3;

	// Transfer phases.
	localparam logic [1:0] PH_IDLE       = 2'd0;
	localparam logic [1:0] PH_WAIT_ACK0  = 2'd1;
	localparam logic [1:0] PH_WAIT_BLOCK = 2'd2;
	localparam logic [1:0] PH_WAIT_ACK   = 2'd3;

	// Result action codes.
	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_WRQ       = 3'd1;
	localparam logic [2:0] ACT_SEND      = 3'd2;
	localparam logic [2:0] ACT_FETCH     = 3'd3;
	localparam logic [2:0] ACT_DONE      = 3'd4;
	localparam logic [2:0] ACT_NO_SERVER = 3'd5;
	localparam logic [2:0] ACT_EXHAUSTED = 3'd6;

	localparam logic [15:0] OPCODE_ACK   = 16'd4;
	localparam logic [15:0] HEADER_BYTES = 16'd4;
	localparam logic [15:0] MAX_PAYLOAD  = 16'd65464;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
	localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_MAX_RETX    = 2'd2;

	localparam logic [15:0] RST_BLOCK_SIZE  = 16'd512;
	localparam logic [15:0] RST_ACK_TIMEOUT = 16'd150;
	localparam logic [3:0]  RST_MAX_RETX    = 4'd3;

	typedef struct packed {
		logic [15:0] block_size;
		logic [15:0] ack_timeout_ticks;
		logic [3:0]  max_retransmits;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] rx_length;
		logic [15:0] rx_opcode;
		logic [15:0] rx_block;
		logic [15:0] fetch_bytes;
	} item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] tx_block;
		logic [15:0] tx_length;
		logic        bad_packet;
	} result_t;

endpackage

FILE: hdl/tws_regs.sv
module tws_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output tws_pkg::cfg_t     cfg
);

	logic [15:0] block_size_q;
	logic [15:0] ack_timeout_q;
	logic [3:0]  max_retx_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= tws_pkg::RST_BLOCK_SIZE;
			ack_timeout_q <= tws_pkg::RST_ACK_TIMEOUT;
			max_retx_q    <= tws_pkg::RST_MAX_RETX;
		end else if (wr_en) begin
			case (reg_idx)
				tws_pkg::REG_BLOCK_SIZE:  block_size_q  <= pwdata[15:0];
				tws_pkg::REG_ACK_TIMEOUT: ack_timeout_q <= pwdata[15:0];
				tws_pkg::REG_MAX_RETX:    max_retx_q    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tws_pkg::REG_BLOCK_SIZE:  prdata = {16'd0, block_size_q};
			tws_pkg::REG_ACK_TIMEOUT: prdata = {16'd0, ack_timeout_q};
			tws_pkg::REG_MAX_RETX:    prdata = {28'd0, max_retx_q};
			default:                  prdata = 32'd0;
		endcase
	end

	assign cfg.block_size        = block_size_q;
	assign cfg.ack_timeout_ticks = ack_timeout_q;
	assign cfg.max_retransmits   = max_retx_q;

endmodule

FILE: hdl/tws_core.sv
module tws_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  tws_pkg::item_t   item,
	input  tws_pkg::cfg_t    cfg,
	output tws_pkg::result_t result
);

	logic [1:0]  phase_q,  phase_d;
	logic [15:0] blk_q,    blk_d;
	logic [15:0] wait_q,   wait_d;
	logic [3:0]  tries_q,  tries_d;
	logic [15:0] last_q,   last_d;

	logic [15:0] wait_inc;
	logic        timed_out;
	logic        is_ack;
	logic [15:0] clamp_a;
	logic [15:0] clamp_n;

	assign wait_inc  = (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;
	assign timed_out = wait_inc >= cfg.ack_timeout_ticks;
	assign is_ack    = (item.rx_length >= tws_pkg::HEADER_BYTES) &&
		(item.rx_opcode == tws_pkg::OPCODE_ACK);

	assign clamp_a = (item.fetch_bytes > cfg.block_size) ? cfg.block_size : item.fetch_bytes;
	assign clamp_n = (clamp_a > tws_pkg::MAX_PAYLOAD) ? tws_pkg::MAX_PAYLOAD : clamp_a;

	always_comb begin
		phase_d = phase_q;
		blk_d   = blk_q;
		wait_d  = wait_q;
		tries_d = tries_q;
		last_d  = last_q;
		result.action     = tws_pkg::ACT_NONE;
		result.tx_block   = 16'd0;
		result.tx_length  = 16'd0;
		result.bad_packet = 1'b0;
		case (item.operation)
			tws_pkg::OP_START: begin
				if (phase_q == tws_pkg::PH_IDLE) begin
					phase_d = tws_pkg::PH_WAIT_ACK0;
					blk_d   = 16'd0;
					wait_d  = 16'd0;
					tries_d = 4'd0;
					result.action = tws_pkg::ACT_WRQ;
				end
			end
			tws_pkg::OP_PACKET: begin
				result.bad_packet = (item.rx_length != 16'd0) &&
					(item.rx_length < tws_pkg::HEADER_BYTES);
				if (is_ack && phase_q == tws_pkg::PH_WAIT_ACK0 && item.rx_block == 16'd0) begin
					phase_d = tws_pkg::PH_WAIT_BLOCK;
					blk_d   = 16'd1;
					result.action = tws_pkg::ACT_FETCH;
				end else if (is_ack && phase_q == tws_pkg::PH_WAIT_ACK &&
						item.rx_block == blk_q) begin
					// A full block means more data follows; a short one ends it.
					if (last_q == cfg.block_size) begin
						blk_d   = blk_q + 16'd1;
						phase_d = tws_pkg::PH_WAIT_BLOCK;
						result.action = tws_pkg::ACT_FETCH;
					end else begin
						phase_d = tws_pkg::PH_IDLE;
						result.action = tws_pkg::ACT_DONE;
					end
				end
			end
			tws_pkg::OP_TICK: begin
				if (phase_q == tws_pkg::PH_WAIT_ACK0) begin
					wait_d = wait_inc;
					if (timed_out) begin
						phase_d = tws_pkg::PH_IDLE;
						result.action = tws_pkg::ACT_NO_SERVER;
					end
				end else if (phase_q == tws_pkg::PH_WAIT_ACK) begin
					wait_d = wait_inc;
					if (timed_out) begin
						if (tries_q >= cfg.max_retransmits) begin
							phase_d = tws_pkg::PH_IDLE;
							result.action = tws_pkg::ACT_EXHAUSTED;
						end else begin
							tries_d = tries_q + 4'd1;
							wait_d  = 16'd0;
							result.action    = tws_pkg::ACT_SEND;
							result.tx_block  = blk_q;
							result.tx_length = last_q + tws_pkg::HEADER_BYTES;
						end
					end
				end
			end
			tws_pkg::OP_READY: begin
				if (phase_q == tws_pkg::PH_WAIT_BLOCK) begin
					last_d  = clamp_n;
					tries_d = 4'd1;
					wait_d  = 16'd0;
					phase_d = tws_pkg::PH_WAIT_ACK;
					result.action    = tws_pkg::ACT_SEND;
					result.tx_block  = blk_q;
					result.tx_length = clamp_n + tws_pkg::HEADER_BYTES;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tws_pkg::PH_IDLE;
			blk_q   <= 16'd0;
			wait_q  <= 16'd0;
			tries_q <= 4'd0;
			last_q  <= 16'd0;
		end else if (step) begin
			phase_q <= phase_d;
			blk_q   <= blk_d;
			wait_q  <= wait_d;
			tries_q <= tries_d;
			last_q  <= last_d;
		end
	end

endmodule

FILE: hdl/tftp_write_sender_core.sv
// Control side of a TFTP-style write (upload) transfer.
// Input channel (in_valid/in_ready): one event beat per item, with operation
// selecting start, received packet, timer tick or next block ready, and the
// packet and block fields alongside. Output channel (out_valid/out_ready):
// exactly one result beat per event, carrying the action to take, the block
// number and length of a data packet to send, and a bad-packet flag.
// The APB port holds block size, ACK timeout in ticks and the number of send
// attempts per block; write it only while no event is in flight.
// Events are taken one per cycle while out_ready stays high. An accepted
// beat waits in the input register until the result register is free or
// being emptied; the decision logic then updates the transfer state, and
// the state and the result register load at the same clock edge, which
// raises out_valid for the result beat.
// The result register and the input register together let a new event be
// taken while a finished result still waits; when the receiver stalls both
// fill and in_ready drops until out_ready returns.
// Reset (arst_n low) returns the transfer to idle, clears the block number,
// counters and stored payload size, restores the register defaults, and
// empties both registers.
module tftp_write_sender_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [15:0] rx_length,
	input  logic [15:0] rx_opcode,
	input  logic [15:0] rx_block,
	input  logic [15:0] fetch_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [15:0] tx_block,
	output logic [15:0] tx_length,
	output logic        bad_packet,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	tws_pkg::cfg_t    cfg;
	tws_pkg::item_t   item_s1;
	tws_pkg::result_t result;
	tws_pkg::result_t result_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             advance;
	logic             in_fire;

	assign pready = 1'b1;

	tws_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// The event in the input register is processed when the result register
	// is free or being emptied in the same cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.operation   <= operation;
			item_s1.rx_length   <= rx_length;
			item_s1.rx_opcode   <= rx_opcode;
			item_s1.rx_block    <= rx_block;
			item_s1.fetch_bytes <= fetch_bytes;
		end
	end

	tws_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign action     = result_q.action;
	assign tx_block   = result_q.tx_block;
	assign tx_length  = result_q.tx_length;
	assign bad_packet = result_q.bad_packet;

endmodule

FILE: hdl/tws_checker.sv
module tws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  action,
	input logic [15:0] tx_block,
	input logic [15:0] tx_length,
	input logic        bad_packet
);

	// A stalled result beat stays up.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(action) && $stable(tx_block) &&
			$stable(tx_length) && $stable(bad_packet))
		else $error("result payload changed while stalled");

	// Only a data send carries a block number and length.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != tws_pkg::ACT_SEND |-> tx_block == 16'd0 && tx_length == 16'd0)
		else $error("tx fields set on a non-send action");

	// A data packet always has at least its header.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == tws_pkg::ACT_SEND |-> tx_length >= tws_pkg::HEADER_BYTES)
		else $error("data packet shorter than its header");

	// A runt packet can never advance the transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_packet |-> action == tws_pkg::ACT_NONE)
		else $error("bad packet produced an action");

endmodule

bind tftp_write_sender_core tws_checker u_tws_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.action     (action),
	.tx_block   (tx_block),
	.tx_length  (tx_length),
	.bad_packet (bad_packet)
);
